@@ sv/tvn_pkg.sv @@
// Shared types, constants and the blend function for the trilinear value noise block.
// No dependencies.
package tvn_pkg;

   localparam int TableSize     = 256;
   localparam int IdxBits       = $clog2(TableSize);
   localparam int ValueBits     = 16;
   localparam int CoordFracBits = 16;
   localparam int CoordBits     = 32;
   localparam int FuncBits      = 3;

   localparam logic [FuncBits-1:0] FUNC_QUERY  = 3'd0;
   localparam logic [FuncBits-1:0] FUNC_VALUE  = 3'd1;
   localparam logic [FuncBits-1:0] FUNC_PERM_X = 3'd2;
   localparam logic [FuncBits-1:0] FUNC_PERM_Y = 3'd3;
   localparam logic [FuncBits-1:0] FUNC_PERM_Z = 3'd4;

   typedef struct packed {
      logic                 we;
      logic [IdxBits-1:0]   addr;
      logic [ValueBits-1:0] data;
   } tbl_wr_type;

   // a + floor((b - a) * f / 2^F), equal to (a*(2^F-f) + b*f) >> F
   function automatic logic [ValueBits-1:0] lerp(input logic [ValueBits-1:0] a,
                                                 input logic [ValueBits-1:0] b,
                                                 input logic [CoordFracBits-1:0] f);
      logic signed [ValueBits:0]                   d;
      logic signed [ValueBits+CoordFracBits+1:0]   p;
      logic        [ValueBits+CoordFracBits+1:0]   s;
      d = signed'({1'b0, b}) - signed'({1'b0, a});
      p = d * signed'({1'b0, f});
      s = unsigned'(p) + {2'b00, a, {CoordFracBits{1'b0}}};
      return s[ValueBits+CoordFracBits-1:CoordFracBits];
   endfunction

endpackage

@@ sv/tvn_perm_lookup.sv @@
// One permutation table: one write port, reads at a lattice index and its successor.
// Depends on tvn_pkg.
module tvn_perm_lookup
   import tvn_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  tbl_wr_type         wr,
   input  logic [IdxBits-1:0] base,
   output logic [IdxBits-1:0] q0,
   output logic [IdxBits-1:0] q1
);

   logic [IdxBits-1:0] mem [TableSize];
   logic [IdxBits-1:0] q0_ff;
   logic [IdxBits-1:0] q1_ff;
   logic [IdxBits-1:0] next_idx;

   assign next_idx = base + IdxBits'(1);

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data[IdxBits-1:0];
      end
      if (en) begin
         q0_ff <= mem[base];
         q1_ff <= mem[next_idx];
      end
   end

   assign q0 = q0_ff;
   assign q1 = q1_ff;

endmodule

@@ sv/tvn_value_lookup.sv @@
// Value table replicated into four dual-read copies, giving eight corner reads a beat.
// Depends on tvn_pkg.
module tvn_value_lookup
   import tvn_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  tbl_wr_type           wr,
   input  logic [IdxBits-1:0]   hash [8],
   output logic [ValueBits-1:0] corner [8]
);

   for (genvar k = 0; k < 4; k++) begin : g_copy
      logic [ValueBits-1:0] mem [TableSize];
      logic [ValueBits-1:0] qa_ff;
      logic [ValueBits-1:0] qb_ff;

      always_ff @(posedge clock) begin
         if (wr.we) begin
            mem[wr.addr] <= wr.data;
         end
         if (en) begin
            qa_ff <= mem[hash[2*k]];
            qb_ff <= mem[hash[2*k+1]];
         end
      end

      assign corner[2*k]   = qa_ff;
      assign corner[2*k+1] = qb_ff;
   end

endmodule

@@ sv/trilinear_value_noise_3d.sv @@
// One beat per cycle sustained while rsp_stall does not hold the pipe.
// Stages: permutation read, value read, x blend, y blend, z blend.
// The whole pipe holds while a result waits under rsp_stall.
// Reset (synchronous) clears the valid bits only; tables are undefined until loaded.
// Depends on tvn_pkg, tvn_perm_lookup, tvn_value_lookup.
module trilinear_value_noise_3d
   import tvn_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [FuncBits-1:0]         req_func,
   input  logic signed [CoordBits-1:0] req_coord_x,
   input  logic signed [CoordBits-1:0] req_coord_y,
   input  logic signed [CoordBits-1:0] req_coord_z,
   input  logic [7:0]                  req_table_index,
   input  logic [ValueBits-1:0]        req_table_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ValueBits-1:0]        rsp_noise_value
);

   logic advance;
   logic accept;
   tbl_wr_type wr_val, wr_px, wr_py, wr_pz;

   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic [CoordFracBits-1:0] fx1_ff, fy1_ff, fz1_ff;
   logic [CoordFracBits-1:0] fx2_ff, fy2_ff, fz2_ff;
   logic [CoordFracBits-1:0] fy3_ff, fz3_ff, fz4_ff;
   logic [ValueBits-1:0] x_ff [4];
   logic [ValueBits-1:0] y_ff [2];
   logic [ValueBits-1:0] rsp_noise_value_ff;
   logic [ValueBits-1:0] rsp_noise_value_in;

   logic [IdxBits-1:0] px0, px1, py0, py1, pz0, pz1;
   logic [IdxBits-1:0] hash [8];
   logic [ValueBits-1:0] corner [8];

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_comb begin
      wr_val.we   = accept && (req_func == FUNC_VALUE);
      wr_val.addr = req_table_index[IdxBits-1:0];
      wr_val.data = req_table_data;
      wr_px    = wr_val;
      wr_py    = wr_val;
      wr_pz    = wr_val;
      wr_px.we = accept && (req_func == FUNC_PERM_X);
      wr_py.we = accept && (req_func == FUNC_PERM_Y);
      wr_pz.we = accept && (req_func == FUNC_PERM_Z);
   end

   tvn_perm_lookup u_perm_x (
      .clock(clock), .en(advance), .wr(wr_px),
      .base(req_coord_x[CoordFracBits +: IdxBits]), .q0(px0), .q1(px1));
   tvn_perm_lookup u_perm_y (
      .clock(clock), .en(advance), .wr(wr_py),
      .base(req_coord_y[CoordFracBits +: IdxBits]), .q0(py0), .q1(py1));
   tvn_perm_lookup u_perm_z (
      .clock(clock), .en(advance), .wr(wr_pz),
      .base(req_coord_z[CoordFracBits +: IdxBits]), .q0(pz0), .q1(pz1));

   // corner d: bit 2 = x offset, bit 1 = y offset, bit 0 = z offset
   always_comb begin
      for (int d = 0; d < 8; d++) begin
         hash[d] = (d[2] ? px1 : px0) ^ (d[1] ? py1 : py0) ^ (d[0] ? pz1 : pz0);
      end
   end

   tvn_value_lookup u_value (
      .clock(clock), .en(advance), .wr(wr_val), .hash(hash), .corner(corner));

   assign rsp_noise_value_in = lerp(y_ff[0], y_ff[1], fz4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= accept && (req_func == FUNC_QUERY);
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fx1_ff <= req_coord_x[CoordFracBits-1:0];
         fy1_ff <= req_coord_y[CoordFracBits-1:0];
         fz1_ff <= req_coord_z[CoordFracBits-1:0];
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
         fz2_ff <= fz1_ff;
         for (int i = 0; i < 4; i++) begin
            x_ff[i] <= lerp(corner[i], corner[i+4], fx2_ff);
         end
         fy3_ff <= fy2_ff;
         fz3_ff <= fz2_ff;
         y_ff[0] <= lerp(x_ff[0], x_ff[2], fy3_ff);
         y_ff[1] <= lerp(x_ff[1], x_ff[3], fy3_ff);
         fz4_ff <= fz3_ff;
         rsp_noise_value_ff <= rsp_noise_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == FUNC_QUERY |=> v1_ff)
      else $error("accepted query did not enter pipe");
   a_last_stage_out: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !req_stall |=> rsp_valid)
      else $error("result lost at output stage");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled result changed");
   a_no_load_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func != FUNC_QUERY |=> !v1_ff)
      else $error("load beat produced a result");

endmodule
